// ===== rtl/epa_pkg.sv =====
// Shared constants, types and state codes for the energy pulse accumulator.
// Used by every module in the rtl folder; depends on nothing else.
package epa_pkg;

  // Number of channel accumulators.
  localparam int CHANNELS = 4;

  // Field widths.
  localparam int CHAN_W = 2;
  localparam int DATA_W = 32;

  // The divider works on a 33-bit magnitude, one quotient bit per cycle.
  localparam int DIV_W     = DATA_W + 1;
  localparam int DIV_STEPS = DIV_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/energy_to_pulse_accumulator.sv =====
// Top level of the energy pulse accumulator: sequencer, rate register, output word.
// Depends on epa_pkg, epa_frac_store and epa_serial_div.

// Each input word adds a signed energy increment to the fraction held for its
// channel and floor-divides the sum by unit_rate (a rate of 0 acts as 1). The
// result word gives the whole units (0 with clamped set when the quotient is
// negative, all ones when it exceeds 32 bits) and the new fraction, which is
// stored back. Once a word is accepted, its sum is formed and loaded into the
// bit-serial divider, which runs its 33 steps; a finishing step then loads the
// output register. The input is stalled while a word is in work; a finished
// word waits in the output register, so a new word may be accepted while the
// previous result is still pending. The finishing step waits while that
// register holds a result that is stalled. Write unit_rate only while no word
// is in work and the last result has been taken.
module energy_to_pulse_accumulator (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port.
  input  logic                              cfg_we,
  input  logic        [epa_pkg::DATA_W-1:0] cfg_wdata,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic        [epa_pkg::CHAN_W-1:0] in_channel,
  input  logic signed [epa_pkg::DATA_W-1:0] in_energy_delta,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [epa_pkg::DATA_W-1:0] out_whole_units,
  output logic        [epa_pkg::DATA_W-1:0] out_remainder,
  output logic                              out_clamped
);

  localparam int SUM_W = epa_pkg::DATA_W + 2;

  epa_pkg::state_t            state_r;
  epa_pkg::state_t            state_nxt;
  logic [epa_pkg::DATA_W-1:0] unit_rate_r;
  logic [epa_pkg::DATA_W-1:0] rate_eff;

  logic [epa_pkg::CHAN_W-1:0] chan_r;
  logic                       neg_r;
  logic                       in_range_r;

  logic [epa_pkg::DATA_W-1:0] frac_rd;
  logic                       frac_in_range;
  logic                       frac_we;
  logic [epa_pkg::DATA_W-1:0] frac_wdata;

  logic [SUM_W-1:0]           sum;
  logic [epa_pkg::DIV_W-1:0]  mag;

  epa_pkg::div_ctrl_t         div_ctrl;
  epa_pkg::div_stat_t         div_stat;
  logic [epa_pkg::DIV_W-1:0]  div_quo;
  logic [epa_pkg::DATA_W-1:0] div_rem;

  logic                       accept;
  logic                       out_free;
  logic                       out_load;
  logic [epa_pkg::DATA_W-1:0] units_nxt;
  logic [epa_pkg::DATA_W-1:0] rem_nxt;
  logic                       clamped_nxt;

  logic                       out_valid_r;
  logic [epa_pkg::DATA_W-1:0] out_units_r;
  logic [epa_pkg::DATA_W-1:0] out_rem_r;
  logic                       out_clamped_r;

  // Rate register; a rate of zero is used as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_rate_r <= epa_pkg::DATA_W'(1);
    end else if (cfg_we) begin
      unit_rate_r <= cfg_wdata;
    end
  end

  assign rate_eff = (unit_rate_r == '0) ? epa_pkg::DATA_W'(1) : unit_rate_r;

  // Fraction registers.
  epa_frac_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_chan     (in_channel),
    .rd_data     (frac_rd),
    .rd_in_range (frac_in_range),
    .wr_en       (frac_we),
    .wr_chan     (chan_r),
    .wr_data     (frac_wdata)
  );

  // Exact sum of the held fraction and the increment. A negative sum s is
  // divided as ~s = -s-1, which turns the floor division into an unsigned one.
  always_comb begin
    sum = {2'b00, frac_rd} + {{2{in_energy_delta[epa_pkg::DATA_W-1]}}, in_energy_delta};
    mag = sum[SUM_W-1] ? ~sum[epa_pkg::DIV_W-1:0] : sum[epa_pkg::DIV_W-1:0];
  end

  epa_serial_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .dividend  (mag),
    .divisor   (rate_eff),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      epa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = epa_pkg::ST_DIV;
        end
      end
      epa_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = epa_pkg::ST_DONE;
        end
      end
      epa_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = epa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = epa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= epa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: outputs.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    in_stall       = 1'b1;
    div_ctrl.start = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      epa_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        div_ctrl.start = in_valid;
      end
      epa_pkg::ST_DIV: begin
        in_stall = 1'b1;
      end
      epa_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Facts about the word in work, captured when it is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r     <= in_channel;
      neg_r      <= sum[SUM_W-1];
      in_range_r <= frac_in_range;
    end
  end

  // Finish: floor correction for a negative sum, clamp and saturation.
  always_comb begin
    units_nxt   = '0;
    rem_nxt     = '0;
    clamped_nxt = 1'b0;
    if (in_range_r) begin
      if (neg_r) begin
        rem_nxt     = rate_eff - epa_pkg::DATA_W'(1) - div_rem;
        clamped_nxt = 1'b1;
      end else begin
        rem_nxt   = div_rem;
        units_nxt = div_quo[epa_pkg::DIV_W-1] ? '1 : div_quo[epa_pkg::DATA_W-1:0];
      end
    end
  end

  assign frac_we    = out_load && in_range_r;
  assign frac_wdata = rem_nxt;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_units_r   <= units_nxt;
      out_rem_r     <= rem_nxt;
      out_clamped_r <= clamped_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_whole_units = out_units_r;
  assign out_remainder   = out_rem_r;
  assign out_clamped     = out_clamped_r;

  // An accepted word always starts the divider.
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == epa_pkg::ST_DIV) && div_stat.busy)
    else $error("accepted word did not start the divider");

  // The divider runs whenever the sequencer waits on it.
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == epa_pkg::ST_DIV) |-> div_stat.busy)
    else $error("sequencer waits on an idle divider");

  // A clamped word carries no units.
  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clamped_r) |-> (out_units_r == '0))
    else $error("clamped word has nonzero units");

  // The reported fraction is always below the rate.
  a_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rem_r < rate_eff))
    else $error("remainder not below the rate");

endmodule

// ===== rtl/epa_frac_store.sv =====
// Per-channel fraction registers of the energy pulse accumulator.
// Depends on epa_pkg for the channel count and widths.
module epa_frac_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [epa_pkg::CHAN_W-1:0] rd_chan,
  output logic [epa_pkg::DATA_W-1:0] rd_data,
  output logic                       rd_in_range,
  input  logic                       wr_en,
  input  logic [epa_pkg::CHAN_W-1:0] wr_chan,
  input  logic [epa_pkg::DATA_W-1:0] wr_data
);

  logic [epa_pkg::DATA_W-1:0] store_r [epa_pkg::CHANNELS];

  // Read port: select the addressed entry; a channel beyond the store reads zero.
  always_comb begin
    rd_data     = '0;
    rd_in_range = 1'b0;
    for (int i = 0; i < epa_pkg::CHANNELS; i++) begin
      if (int'(rd_chan) == i) begin
        rd_data     = store_r[i];
        rd_in_range = 1'b1;
      end
    end
  end

  // Write port: all fractions start at zero after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < epa_pkg::CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < epa_pkg::CHANNELS; i++) begin
        if (wr_en && (int'(wr_chan) == i)) begin
          store_r[i] <= wr_data;
        end
      end
    end
  end

endmodule

// ===== rtl/epa_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle over a 33-bit dividend.
// Depends on epa_pkg for widths, step count and the control and status structs.
module epa_serial_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  epa_pkg::div_ctrl_t         ctrl,
  input  logic [epa_pkg::DIV_W-1:0]  dividend,
  input  logic [epa_pkg::DATA_W-1:0] divisor,
  output epa_pkg::div_stat_t         stat,
  output logic [epa_pkg::DIV_W-1:0]  quotient,
  output logic [epa_pkg::DATA_W-1:0] remainder
);

  localparam logic [epa_pkg::CNT_W-1:0] LAST_STEP = epa_pkg::CNT_W'(epa_pkg::DIV_STEPS - 1);

  logic                       busy_r;
  logic [epa_pkg::CNT_W-1:0]  cnt_r;
  logic [epa_pkg::DIV_W-1:0]  quo_r;
  logic [epa_pkg::DIV_W-1:0]  quo_nxt;
  logic [epa_pkg::DATA_W-1:0] rem_r;
  logic [epa_pkg::DATA_W-1:0] rem_nxt;
  logic [epa_pkg::DIV_W-1:0]  trial;
  logic [epa_pkg::DIV_W:0]    diff;
  logic                       fits;

  // One restoring step: shift the next dividend bit into the partial remainder
  // and subtract the divisor when it fits.
  always_comb begin
    trial   = {rem_r, quo_r[epa_pkg::DIV_W-1]};
    diff    = {1'b0, trial} - {2'b00, divisor};
    fits    = ~diff[epa_pkg::DIV_W];
    rem_nxt = fits ? diff[epa_pkg::DATA_W-1:0] : trial[epa_pkg::DATA_W-1:0];
    quo_nxt = {quo_r[epa_pkg::DIV_W-2:0], fits};
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Dividend and quotient share one shift register.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == LAST_STEP);
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for energy_to_pulse_accumulator: directed and random words,
// with idling and stalls on both channels, checked against an energy ledger scoreboard.
// Depends on epa_pkg and the energy_to_pulse_accumulator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RUN_LIMIT     = 1_000_000;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     PHASE_WORDS   = 140;
  localparam int     REPORT_LIMIT  = 10;
  localparam longint MAX_UNITS     = 64'h0000_0000_FFFF_FFFF;

  // One expected result word.
  typedef struct packed {
    logic [epa_pkg::DATA_W-1:0] units;
    logic [epa_pkg::DATA_W-1:0] rem;
    logic                       clamped;
  } pulse_word_t;

  // Scoreboard: keeps its own copy of the rate and the per-channel fractions and
  // queues the result that each accepted word should produce.
  class energy_ledger;
    logic [epa_pkg::DATA_W-1:0] rate;
    logic [epa_pkg::DATA_W-1:0] fraction [epa_pkg::CHANNELS];
    pulse_word_t                pending_pulses [$];
    int                         mismatches;

    function new();
      rate = 1;
      foreach (fraction[i]) fraction[i] = '0;
      mismatches = 0;
    endfunction

    function void set_rate(logic [epa_pkg::DATA_W-1:0] value);
      rate = value;
    endfunction

    function int pending();
      return pending_pulses.size();
    endfunction

    // Floor-divide fraction plus increment by the rate and queue the result.
    function void note_word(logic [epa_pkg::CHAN_W-1:0] chan,
                            logic [epa_pkg::DATA_W-1:0] delta);
      longint      divisor;
      longint      total;
      longint      quo;
      longint      rem;
      longint      held;
      longint      step;
      pulse_word_t w;
      held    = {32'b0, fraction[chan]};
      step    = {{32{delta[epa_pkg::DATA_W-1]}}, delta};
      divisor = (rate == 0) ? 64'd1 : {32'b0, rate};
      total   = held + step;
      quo     = total / divisor;
      rem     = total % divisor;
      if (rem < 0) begin
        rem = rem + divisor;
        quo = quo - 1;
      end
      w.clamped = (quo < 0);
      if (quo < 0) begin
        w.units = '0;
      end else if (quo > MAX_UNITS) begin
        w.units = '1;
      end else begin
        w.units = quo[epa_pkg::DATA_W-1:0];
      end
      w.rem          = rem[epa_pkg::DATA_W-1:0];
      fraction[chan] = w.rem;
      pending_pulses.push_back(w);
    endfunction

    // Compare a result word with the oldest expectation.
    function void check_result(logic [epa_pkg::DATA_W-1:0] units,
                               logic [epa_pkg::DATA_W-1:0] rem,
                               logic clamped);
      pulse_word_t w;
      if (pending_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result word: units=%h rem=%h clamped=%b",
                   units, rem, clamped);
        return;
      end
      w = pending_pulses.pop_front();
      if (units !== w.units || rem !== w.rem || clamped !== w.clamped) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"result mismatch: expected units=%h rem=%h clamped=%b,",
                    " got units=%h rem=%h clamped=%b"},
                   w.units, w.rem, w.clamped, units, rem, clamped);
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic        [epa_pkg::DATA_W-1:0] cfg_wdata;
  logic                              in_valid;
  logic                              in_stall;
  logic        [epa_pkg::CHAN_W-1:0] in_channel;
  logic signed [epa_pkg::DATA_W-1:0] in_energy_delta;
  logic                              out_valid;
  logic                              out_stall;
  logic        [epa_pkg::DATA_W-1:0] out_whole_units;
  logic        [epa_pkg::DATA_W-1:0] out_remainder;
  logic                              out_clamped;

  energy_ledger ledger;
  int           sender_pct;
  int           stall_pct;
  int           stall_hold;
  int           cycles;

  energy_to_pulse_accumulator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_channel      (in_channel),
    .in_energy_delta (in_energy_delta),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_whole_units (out_whole_units),
    .out_remainder   (out_remainder),
    .out_clamped     (out_clamped)
  );

  // 10 ns clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run limit.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Watch both handshakes at the rising edge.
  always @(posedge clk) begin
    if (rst_n && ledger != null) begin
      if (in_valid && !in_stall)
        ledger.note_word(in_channel, in_energy_delta);
      if (out_valid && !out_stall)
        ledger.check_result(out_whole_units, out_remainder, out_clamped);
    end
  end

  // Result side: random stalls, with an occasional long hold so that a finished
  // word has to wait in the output register.
  always @(negedge clk) begin
    if (stall_pct == 0) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      out_stall  <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(49) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(20, 80);
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic [epa_pkg::CHAN_W-1:0] chan,
                           input logic [epa_pkg::DATA_W-1:0] delta);
    int gap;
    gap = 0;
    if (sender_pct > 0) begin
      if ($urandom_range(7) == 0) begin
        gap = $urandom_range(1, 45);
      end else begin
        while ($urandom_range(99) < sender_pct) gap++;
      end
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_channel      <= chan;
    in_energy_delta <= delta;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every result is in and the block has settled.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the rate register while the block is idle.
  task automatic write_rate(input logic [epa_pkg::DATA_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    ledger.set_rate(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Increment mix: full random, small signed, extremes, and near multiples of the rate.
  function automatic logic [epa_pkg::DATA_W-1:0] pick_delta(
      input logic [epa_pkg::DATA_W-1:0] rate);
    logic [epa_pkg::DATA_W-1:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = epa_pkg::DATA_W'($urandom_range(0, 2000)) - epa_pkg::DATA_W'(1000);
      2: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      3: v = rate * epa_pkg::DATA_W'($urandom_range(0, 3))
             + epa_pkg::DATA_W'($urandom_range(0, 4)) - epa_pkg::DATA_W'(2);
      default: v = -(rate * epa_pkg::DATA_W'($urandom_range(0, 2)))
                   - epa_pkg::DATA_W'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  // Stimulus.
  initial begin
    logic [epa_pkg::DATA_W-1:0] phase_rates [8];
    int                         pcts [4][2];
    int                         p;

    phase_rates = '{32'd7, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1000, 32'h8000_0000, 32'd2, 32'd0};
    phase_rates[7] = $urandom_range(3, 100000);
    pcts = '{'{0, 0}, '{54, 0}, '{0, 54}, '{35, 35}};

    ledger          = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_channel      = '0;
    in_energy_delta = '0;
    out_stall       = 1'b0;
    stall_hold      = 0;
    sender_pct      = 0;
    stall_pct       = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset rate of one, extremes of the increment, negative quotient.
    send_word(2'd0, 32'h7FFF_FFFF);
    send_word(2'd1, 32'h8000_0000);
    send_word(2'd2, 32'h0000_0000);
    send_word(2'd3, 32'hFFFF_FFFF);

    // Largest rate: fractions grow to rate-1, then roll over into one unit.
    write_rate(32'hFFFF_FFFF);
    send_word(2'd0, 32'h7FFF_FFFF);
    send_word(2'd0, 32'h7FFF_FFFF);
    send_word(2'd0, 32'h0000_0001);
    send_word(2'd1, 32'h7FFF_FFFF);
    send_word(2'd1, 32'h7FFF_FFFF);
    send_word(2'd2, 32'hFFFF_FFFB);
    send_word(2'd3, 32'h8000_0000);

    // Back to a rate of one: stale large fractions, quotient overflow.
    write_rate(32'd1);
    send_word(2'd1, 32'h7FFF_FFFF);
    send_word(2'd2, 32'h8000_0000);
    send_word(2'd3, 32'h7FFF_FFFF);

    // A rate of zero acts as one.
    write_rate(32'd0);
    send_word(2'd3, 32'd100);
    send_word(2'd0, 32'hFFFF_FFF9);

    // Small rate with carries through the fraction.
    write_rate(32'd3);
    send_word(2'd0, 32'd2);
    send_word(2'd0, 32'd2);
    send_word(2'd1, 32'hFFFF_FFFE);
    send_word(2'd2, 32'h7FFF_FFFF);
    send_word(2'd3, 32'h8000_0000);

    // Random phases: each with its own rate and idling pattern.
    for (p = 0; p < 8; p++) begin
      write_rate(phase_rates[p]);
      sender_pct = pcts[p % 4][0];
      stall_pct  = pcts[p % 4][1];
      repeat (PHASE_WORDS) begin
        send_word(epa_pkg::CHAN_W'($urandom), pick_delta(phase_rates[p]));
      end
      // Part of each phase runs without idling.
      sender_pct = 0;
      stall_pct  = 0;
      repeat (4) send_word(epa_pkg::CHAN_W'($urandom), pick_delta(phase_rates[p]));
    end

    drain();
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
